// ----- rtl/byte_level_pretoken_splitter_defines.svh -----
// ----------------------------------------------------------------------------
// Byte-level pre-token splitter: assertion macros
// Shared helpers for the concurrent checks on the splitter's ports.
// ----------------------------------------------------------------------------
`ifndef BYTE_LEVEL_PRETOKEN_SPLITTER_DEFINES_SVH
`define BYTE_LEVEL_PRETOKEN_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BLPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/blps_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte-level pre-token splitter package
// Request types, span kinds, byte classes and the byte-to-unicode mapping.
// ----------------------------------------------------------------------------
package blps_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [8:0]  code_point;
        logic [15:0] utf8_bytes;
        logic [1:0]  utf8_length;
        logic        span_start;
        logic        text_end;
        logic        burst_last;
    } t_out_req;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_LETTER   = 3'd1,
        KIND_DIGIT    = 3'd2,
        KIND_WS       = 3'd3,
        KIND_OTHER_SP = 3'd4,
        KIND_OTHER    = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] cleft;
    } t_span_st;

    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6C;

    localparam logic [1:0] UTF8_LEN_ONE = 2'd1;
    localparam logic [1:0] UTF8_LEN_TWO = 2'd2;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_other(input logic [7:0] b);
        return !is_ws(b) && !is_alpha(b) && !is_num(b);
    endfunction

    // Byte-to-unicode code point: printable bytes map to themselves, the
    // rest are packed from 256 upward in byte order.
    function automatic logic [8:0] map_byte(input logic [7:0] b);
        logic [8:0] cp;
        if (b <= 8'h20) begin
            cp = 9'd256 + {1'b0, b};
        end else if (b >= 8'h7F && b <= 8'hA0) begin
            cp = 9'd289 + ({1'b0, b} - 9'h07F);
        end else if (b == 8'hAD) begin
            cp = 9'd323;
        end else begin
            cp = {1'b0, b};
        end
        return cp;
    endfunction

    function automatic logic continues(input t_kind kind, input logic [7:0] b);
        logic c;
        case (kind)
            KIND_LETTER:   c = is_alpha(b);
            KIND_DIGIT:    c = is_num(b);
            KIND_WS:       c = is_ws(b);
            KIND_OTHER_SP: c = is_other(b);
            KIND_OTHER:    c = is_other(b) && b != CH_APOS;
            default:       c = 1'b0;
        endcase
        return c;
    endfunction

    // Rule selection at a span start, looking up to two bytes ahead.
    function automatic t_span_st open_span(input logic [7:0] b,
                                           input logic h1, input logic [7:0] n1,
                                           input logic h2, input logic [7:0] n2);
        t_span_st s;
        s.kind  = KIND_NONE;
        s.cleft = 2'd0;
        if (b == CH_APOS) begin
            if (h1 && (n1 == CH_S || n1 == CH_T || n1 == CH_M || n1 == CH_D)) begin
                s.cleft = 2'd1;
            end else if (h1 && h2 && (n1 == CH_R || n1 == CH_V) && n2 == CH_E) begin
                s.cleft = 2'd2;
            end else if (h1 && h2 && n1 == CH_L && n2 == CH_L) begin
                s.cleft = 2'd2;
            end
        end else if (b == CH_SPACE && h1 && is_alpha(n1)) begin
            s.kind = KIND_LETTER;
        end else if (is_alpha(b)) begin
            s.kind = KIND_LETTER;
        end else if (b == CH_SPACE && h1 && is_num(n1)) begin
            s.kind = KIND_DIGIT;
        end else if (is_num(b)) begin
            s.kind = KIND_DIGIT;
        end else if (b == CH_SPACE) begin
            s.kind = (h1 && is_other(n1)) ? KIND_OTHER_SP : KIND_WS;
        end else if (is_ws(b)) begin
            s.kind = KIND_WS;
        end else begin
            s.kind = KIND_OTHER;
        end
        return s;
    endfunction

endpackage

// ----- rtl/byte_level_pretoken_splitter.sv -----
// ----------------------------------------------------------------------------
// Byte-level pre-token splitter
// Marks pre-token span starts in a raw byte stream and maps every byte to
// its byte-to-unicode code point and UTF-8 encoding.
// ----------------------------------------------------------------------------
//
//  channel | valid       | ready       | payload   | moves
//  --------+-------------+-------------+-----------+------------------------
//  in      | i_in_valid  | o_in_ready  | i_in_req  | one raw text byte
//  out     | o_out_valid | i_out_ready | o_out_req | one mapped, marked byte
//
//  One input request per cycle in steady flow while the output takes every
//  result; each result leaves two bytes behind its input, from a single
//  output register. A request with last_byte set is appended to the window
//  and starts a drain: the window drains one result per cycle, unless the
//  output stalls, while input is held off.
//  A stall on the output holds the result register and drops o_in_ready.
//  Reset (synchronous, active low) empties the window and the result slot.
//
module byte_level_pretoken_splitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  blps_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output blps_pkg::t_out_req o_out_req
);
    import blps_pkg::*;

    // Three-byte window: the byte to emit and one lookahead byte, plus the
    // final byte while draining at end of text.
    logic [7:0] r_win [3];
    logic [7:0] n_win [3];
    logic [1:0] r_cnt,   n_cnt;
    logic       r_flush, n_flush;
    t_kind      r_kind,  n_kind;
    logic [1:0] r_cleft, n_cleft;
    logic       r_ovalid, n_ovalid;
    t_out_req   r_out,    n_out;

    logic       slot_free;
    logic       in_acc;
    logic       emit_go;
    logic       emit_flush;
    logic [7:0] e_b, e_n1, e_n2;
    logic       e_h1, e_h2, e_fin;
    logic       e_start;
    t_span_st   e_open;
    logic [8:0] e_cp;

    assign slot_free  = !r_ovalid || i_out_ready;
    assign o_in_ready = !r_flush && slot_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign emit_flush = r_flush && slot_free;
    assign emit_go    = emit_flush || (in_acc && !i_in_req.last_byte && r_cnt == 2'd2);

    // Operands of the one emit unit: while draining the window supplies the
    // lookahead, in steady flow the incoming byte is the second lookahead.
    always_comb begin
        e_b   = r_win[0];
        e_n1  = r_win[1];
        e_n2  = r_flush ? r_win[2] : i_in_req.data_byte;
        e_h1  = r_flush ? (r_cnt >= 2'd2) : 1'b1;
        e_h2  = r_flush ? (r_cnt == 2'd3) : 1'b1;
        e_fin = r_flush && r_cnt == 2'd1;
        // Contraction bytes and run continuation both suppress a new span.
        e_start = (r_cleft == 2'd0) && !continues(r_kind, e_b);
        e_open  = open_span(e_b, e_h1, e_n1, e_h2, e_n2);
        e_cp    = map_byte(e_b);
    end

    always_comb begin
        n_win    = r_win;
        n_cnt    = r_cnt;
        n_flush  = r_flush;
        n_kind   = r_kind;
        n_cleft  = r_cleft;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;

        if (emit_go) begin
            n_ovalid          = 1'b1;
            n_out.code_point  = e_cp;
            if (e_cp < 9'd128) begin
                n_out.utf8_bytes  = {e_cp[7:0], 8'h00};
                n_out.utf8_length = UTF8_LEN_ONE;
            end else begin
                n_out.utf8_bytes  = {8'hC0 | {5'd0, e_cp[8:6]}, 8'h80 | {2'd0, e_cp[5:0]}};
                n_out.utf8_length = UTF8_LEN_TWO;
            end
            n_out.span_start  = e_start;
            n_out.text_end    = e_fin;
            // Steady flow gives one result per request; a drain marks only its last.
            n_out.burst_last  = r_flush ? e_fin : 1'b1;
            if (r_cleft != 2'd0) begin
                n_cleft = r_cleft - 2'd1;
            end else if (e_start) begin
                n_kind  = e_open.kind;
                n_cleft = e_open.cleft;
            end
        end

        if (in_acc) begin
            if (i_in_req.last_byte || r_cnt != 2'd2) begin
                // Append at the fill point; a final byte starts the drain.
                case (r_cnt)
                    2'd0:    n_win[0] = i_in_req.data_byte;
                    2'd1:    n_win[1] = i_in_req.data_byte;
                    default: n_win[2] = i_in_req.data_byte;
                endcase
                n_cnt   = r_cnt + 2'd1;
                n_flush = i_in_req.last_byte;
            end else begin
                n_win[0] = r_win[1];
                n_win[1] = i_in_req.data_byte;
            end
        end

        if (emit_flush) begin
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            if (r_cnt == 2'd1) begin
                // End of text: back to a fresh text and a fresh span.
                n_cnt   = 2'd0;
                n_flush = 1'b0;
                n_kind  = KIND_NONE;
                n_cleft = 2'd0;
            end else begin
                n_cnt = r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_flush  <= 1'b0;
            r_kind   <= KIND_NONE;
            r_cleft  <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_flush  <= n_flush;
            r_kind   <= n_kind;
            r_cleft  <= n_cleft;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_out <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_req   = r_out;

endmodule

// ----- rtl/blps_checker.sv -----
// ----------------------------------------------------------------------------
// Byte-level pre-token splitter checker
// Port-level checks on the splitter's result stream and input flow.
// ----------------------------------------------------------------------------
`include "byte_level_pretoken_splitter_defines.svh"

module blps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input blps_pkg::t_in_req  i_in_req,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input blps_pkg::t_out_req o_out_req
);
    import blps_pkg::*;

    // Set at reset and after a text end: the next result opens a span.
    logic r_after_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_end <= 1'b1;
        end else if (o_out_valid && i_out_ready) begin
            r_after_end <= o_out_req.text_end;
        end
    end

    `BLPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_req), "result changed while stalled")
    `BLPS_ASSERT_NOW(a_end_burst, i_clk, i_rst_n, o_out_valid && o_out_req.text_end, o_out_req.burst_last, "text end without burst end")
    `BLPS_ASSERT_NOW(a_utf8_len, i_clk, i_rst_n, o_out_valid, (o_out_req.code_point < 9'd128) == (o_out_req.utf8_length == UTF8_LEN_ONE), "UTF-8 length mismatch")
    `BLPS_ASSERT_NOW(a_text_start, i_clk, i_rst_n, o_out_valid && r_after_end, o_out_req.span_start, "text does not open a span")
    `BLPS_ASSERT_NEXT(a_drain_hold, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_req.last_byte, !o_in_ready, "input taken during drain")

endmodule

bind byte_level_pretoken_splitter blps_checker u_blps_checker (.*);
